// File: src/voxel_face_culling_mesher_unit_macros.svh
// assertion macros shared by the voxel mesher modules
`ifndef VOXEL_FACE_CULLING_MESHER_UNIT_MACROS_SVH
`define VOXEL_FACE_CULLING_MESHER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define VFCM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define VFCM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/vfcm_pkg.sv
// shared constants, types and tables of the voxel mesher
package vfcm_pkg;

    // grid geometry
    localparam int SECTION_SIZE = 16;
    localparam int COORD_W      = $clog2(SECTION_SIZE);
    localparam int CELL_COUNT   = SECTION_SIZE * SECTION_SIZE * SECTION_SIZE;
    localparam int ADDR_W       = $clog2(CELL_COUNT);

    // field widths
    localparam int CELL_W      = 7;
    localparam int VOXEL_W     = 8;
    localparam int BASE_W      = 24;
    localparam int VERT_W      = 25;
    localparam int NORM_W      = 2;
    localparam int FUNC_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_FIELDS_W  = VOXEL_W + 3 * VERT_W + 3 * NORM_W;
    localparam int M_TDATA_W   = 96;

    // mesh geometry
    localparam int NUM_FACES      = 6;
    localparam int VERTS_PER_FACE = 6;
    localparam int FACE_W         = 3;
    localparam int PROBE_W        = 3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MESH  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_Z = 2'd2;

    // face order of the mesh walk
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd5;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [FACE_W-1:0]  face_idx_t;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_READ_OOB,
        OP_MESH
    } op_t;

    typedef struct packed {
        op_t                 op;
        coord_t              x;
        coord_t              y;
        coord_t              z;
        logic [VOXEL_W-1:0]  value;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_OUT,
        ST_PROBE,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] z;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] x;
    } norm_t;

    // unit-cube corner offsets per face and vertex, bit 0 x, bit 1 y, bit 2 z
    localparam logic [2:0] CORNER_TAB [NUM_FACES][VERTS_PER_FACE] = '{
        '{3'b000, 3'b100, 3'b110, 3'b000, 3'b110, 3'b010},
        '{3'b101, 3'b001, 3'b011, 3'b101, 3'b011, 3'b111},
        '{3'b001, 3'b000, 3'b010, 3'b001, 3'b010, 3'b011},
        '{3'b100, 3'b101, 3'b111, 3'b100, 3'b111, 3'b110},
        '{3'b000, 3'b001, 3'b101, 3'b000, 3'b101, 3'b100},
        '{3'b110, 3'b111, 3'b011, 3'b110, 3'b011, 3'b010}
    };

    // linear store address of a cell
    function automatic logic [ADDR_W-1:0] cell_addr(coord_t x, coord_t y, coord_t z);
        int a;
        a = (int'(x) * SECTION_SIZE + int'(y)) * SECTION_SIZE + int'(z);
        return ADDR_W'(a);
    endfunction

    // outward normal of a face
    function automatic norm_t face_normal(face_idx_t f);
        norm_t n;
        n = '0;
        case (f)
            FACE_NEG_X: n.x = -2'sd1;
            FACE_POS_X: n.x = 2'sd1;
            FACE_NEG_Z: n.z = -2'sd1;
            FACE_POS_Z: n.z = 2'sd1;
            FACE_NEG_Y: n.y = -2'sd1;
            FACE_POS_Y: n.y = 2'sd1;
            default:    n = '0;
        endcase
        return n;
    endfunction

    // lowest set face in a mask
    function automatic face_idx_t first_face(logic [NUM_FACES-1:0] m);
        face_idx_t f;
        f = '0;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (m[i]) begin
                f = FACE_W'(i);
            end
        end
        return f;
    endfunction

endpackage

// File: src/vfcm_ram.sv
// generic single-write, single-read ram with registered read data
module vfcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/vfcm_front.sv
// front end: accepts items, classifies them and queues commands for the back end
`include "voxel_face_culling_mesher_unit_macros.svh"

module vfcm_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cell_x[6:0], cell_y[13:7], cell_z[20:14], voxel_value[28:21], zero pad
    input  logic [vfcm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [vfcm_pkg::FUNC_W-1:0]       s_axis_tuser,
    input  logic                              clear_busy,
    output logic                              q_valid,
    output vfcm_pkg::cmd_t                    q_entry,
    input  logic                              q_pop
);

    logic [vfcm_pkg::CELL_W-1:0]  cell_x;
    logic [vfcm_pkg::CELL_W-1:0]  cell_y;
    logic [vfcm_pkg::CELL_W-1:0]  cell_z;
    logic [vfcm_pkg::VOXEL_W-1:0] voxel_value;
    logic                         in_bounds;
    logic                         interior;
    logic                         accept;
    logic                         push;
    vfcm_pkg::cmd_t               cmd;

    vfcm_pkg::cmd_t                entries_reg [vfcm_pkg::QUEUE_DEPTH];
    logic [vfcm_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [vfcm_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [vfcm_pkg::QCNT_W-1:0]   count_reg, count_next;

    // unpack the item
    assign cell_x      = s_axis_tdata[6:0];
    assign cell_y      = s_axis_tdata[13:7];
    assign cell_z      = s_axis_tdata[20:14];
    assign voxel_value = s_axis_tdata[28:21];

    // bounds checks
    localparam logic [vfcm_pkg::CELL_W-1:0] SIZE_C = vfcm_pkg::CELL_W'(vfcm_pkg::SECTION_SIZE);
    localparam logic [vfcm_pkg::CELL_W-1:0] HIGH_C =
        vfcm_pkg::CELL_W'(vfcm_pkg::SECTION_SIZE - 2);
    localparam logic [vfcm_pkg::CELL_W-1:0] ONE_C = vfcm_pkg::CELL_W'(1);

    assign in_bounds = (cell_x < SIZE_C) && (cell_y < SIZE_C) && (cell_z < SIZE_C);
    assign interior  = (cell_x >= ONE_C) && (cell_x <= HIGH_C) &&
                       (cell_y >= ONE_C) && (cell_y <= HIGH_C) &&
                       (cell_z >= ONE_C) && (cell_z <= HIGH_C);

    assign s_axis_tready = !clear_busy && (count_reg != vfcm_pkg::QCNT_W'(vfcm_pkg::QUEUE_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    // classify: out-of-range writes, border-cell meshes and unused function codes are dropped here
    always_comb begin
        cmd.x     = vfcm_pkg::COORD_W'(cell_x);
        cmd.y     = vfcm_pkg::COORD_W'(cell_y);
        cmd.z     = vfcm_pkg::COORD_W'(cell_z);
        cmd.value = voxel_value;
        cmd.op    = vfcm_pkg::OP_WRITE;
        push      = 1'b0;
        unique case (s_axis_tuser)
            vfcm_pkg::FUNC_WRITE: begin
                cmd.op = vfcm_pkg::OP_WRITE;
                push   = accept && in_bounds;
            end
            vfcm_pkg::FUNC_READ: begin
                cmd.op = in_bounds ? vfcm_pkg::OP_READ : vfcm_pkg::OP_READ_OOB;
                push   = accept;
            end
            vfcm_pkg::FUNC_MESH: begin
                cmd.op = vfcm_pkg::OP_MESH;
                push   = accept && interior;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // queue pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == vfcm_pkg::QPTR_W'(vfcm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == vfcm_pkg::QPTR_W'(vfcm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= cmd;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_entry = entries_reg[rd_ptr_reg];

    `VFCM_ASSERT_SAME(a_no_push_when_full, aclk, aresetn, count_reg == vfcm_pkg::QCNT_W'(vfcm_pkg::QUEUE_DEPTH), !push, "command pushed into a full queue")
    `VFCM_ASSERT_SAME(a_no_pop_when_empty, aclk, aresetn, count_reg == '0, !q_pop, "command popped from an empty queue")

endmodule

// File: src/vfcm_back.sv
// back end: voxel store, configuration, read and mesh sequencer, output register
`include "voxel_face_culling_mesher_unit_macros.svh"

module vfcm_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vfcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vfcm_pkg::BASE_W-1:0]       cfg_data,
    input  logic                              q_valid,
    input  vfcm_pkg::cmd_t                    q_entry,
    output logic                              q_pop,
    output logic                              clear_busy,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [vfcm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int ADDR_W  = vfcm_pkg::ADDR_W;
    localparam int VERT_W  = vfcm_pkg::VERT_W;
    localparam int COORD_W = vfcm_pkg::COORD_W;

    vfcm_pkg::back_state_t state_reg, state_next;

    logic [vfcm_pkg::BASE_W-1:0]    base_x_reg, base_x_next;
    logic [vfcm_pkg::BASE_W-1:0]    base_y_reg, base_y_next;
    logic [vfcm_pkg::BASE_W-1:0]    base_z_reg, base_z_next;

    logic [ADDR_W-1:0]              clr_cnt_reg, clr_cnt_next;
    vfcm_pkg::coord_t               x_reg, x_next;
    vfcm_pkg::coord_t               y_reg, y_next;
    vfcm_pkg::coord_t               z_reg, z_next;
    logic                           oob_reg, oob_next;
    logic [VERT_W-1:0]              pos_x_reg, pos_x_next;
    logic [VERT_W-1:0]              pos_y_reg, pos_y_next;
    logic [VERT_W-1:0]              pos_z_reg, pos_z_next;
    logic [vfcm_pkg::PROBE_W-1:0]   probe_cnt_reg, probe_cnt_next;
    logic                           center_nz_reg, center_nz_next;
    logic [vfcm_pkg::NUM_FACES-1:0] empty_mask_reg, empty_mask_next;
    vfcm_pkg::face_idx_t            face_reg, face_next;
    logic [2:0]                     vert_reg, vert_next;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic                           out_is_vertex_reg, out_is_vertex_next;
    logic [vfcm_pkg::VOXEL_W-1:0]   out_read_value_reg, out_read_value_next;
    logic [VERT_W-1:0]              out_vert_x_reg, out_vert_x_next;
    logic [VERT_W-1:0]              out_vert_y_reg, out_vert_y_next;
    logic [VERT_W-1:0]              out_vert_z_reg, out_vert_z_next;
    vfcm_pkg::norm_t                out_norm_reg, out_norm_next;
    logic                           out_last_reg, out_last_next;
    logic                           out_free;
    logic                           out_load;

    // ram ports
    logic                           ram_wr_en;
    logic [ADDR_W-1:0]              ram_wr_addr;
    logic [vfcm_pkg::VOXEL_W-1:0]   ram_wr_data;
    logic                           ram_rd_en;
    logic [ADDR_W-1:0]              ram_rd_addr;
    logic [vfcm_pkg::VOXEL_W-1:0]   ram_rd_data;

    // mesh helpers
    vfcm_pkg::face_idx_t            probe_face;
    vfcm_pkg::coord_t               nbr_x, nbr_y, nbr_z;
    logic [vfcm_pkg::NUM_FACES-1:0] higher_mask;
    logic                           more_faces;
    logic [2:0]                     corner;

    vfcm_ram #(
        .WIDTH (vfcm_pkg::VOXEL_W),
        .DEPTH (vfcm_pkg::CELL_COUNT)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        base_x_next = base_x_reg;
        base_y_next = base_y_reg;
        base_z_next = base_z_reg;
        if (cfg_valid) begin
            case (cfg_index)
                vfcm_pkg::REG_BASE_X: base_x_next = cfg_data;
                vfcm_pkg::REG_BASE_Y: base_y_next = cfg_data;
                vfcm_pkg::REG_BASE_Z: base_z_next = cfg_data;
                default: ;
            endcase
        end
    end

    // neighbor of the cell for the face being probed
    assign probe_face = vfcm_pkg::FACE_W'(probe_cnt_reg - 1'b1);

    always_comb begin
        nbr_x = x_reg;
        nbr_y = y_reg;
        nbr_z = z_reg;
        case (probe_face)
            vfcm_pkg::FACE_NEG_X: nbr_x = x_reg - COORD_W'(1);
            vfcm_pkg::FACE_POS_X: nbr_x = x_reg + COORD_W'(1);
            vfcm_pkg::FACE_NEG_Z: nbr_z = z_reg - COORD_W'(1);
            vfcm_pkg::FACE_POS_Z: nbr_z = z_reg + COORD_W'(1);
            vfcm_pkg::FACE_NEG_Y: nbr_y = y_reg - COORD_W'(1);
            vfcm_pkg::FACE_POS_Y: nbr_y = y_reg + COORD_W'(1);
            default: ;
        endcase
    end

    // remaining open faces after the current one
    assign higher_mask = empty_mask_reg &
                         ~((vfcm_pkg::NUM_FACES'(2) << face_reg) - vfcm_pkg::NUM_FACES'(1));
    assign more_faces  = |higher_mask;
    assign corner      = vfcm_pkg::CORNER_TAB[face_reg][vert_reg];

    assign out_free = !m_valid_reg || m_axis_tready;
    assign clear_busy = (state_reg == vfcm_pkg::ST_CLEAR);

    // sequencer
    always_comb begin
        state_next          = state_reg;
        clr_cnt_next        = clr_cnt_reg;
        x_next              = x_reg;
        y_next              = y_reg;
        z_next              = z_reg;
        oob_next            = oob_reg;
        pos_x_next          = pos_x_reg;
        pos_y_next          = pos_y_reg;
        pos_z_next          = pos_z_reg;
        probe_cnt_next      = probe_cnt_reg;
        center_nz_next      = center_nz_reg;
        empty_mask_next     = empty_mask_reg;
        face_next           = face_reg;
        vert_next           = vert_reg;
        q_pop               = 1'b0;
        ram_wr_en           = 1'b0;
        ram_wr_addr         = clr_cnt_reg;
        ram_wr_data         = '0;
        ram_rd_en           = 1'b0;
        ram_rd_addr         = vfcm_pkg::cell_addr(x_reg, y_reg, z_reg);
        out_load            = 1'b0;
        out_is_vertex_next  = out_is_vertex_reg;
        out_read_value_next = out_read_value_reg;
        out_vert_x_next     = out_vert_x_reg;
        out_vert_y_next     = out_vert_y_reg;
        out_vert_z_next     = out_vert_z_reg;
        out_norm_next       = out_norm_reg;
        out_last_next       = out_last_reg;

        unique case (state_reg)
            // zero the store after reset
            vfcm_pkg::ST_CLEAR: begin
                ram_wr_en = 1'b1;
                if (clr_cnt_reg == ADDR_W'(vfcm_pkg::CELL_COUNT - 1)) begin
                    state_next = vfcm_pkg::ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            // take the next command
            vfcm_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop  = 1'b1;
                    x_next = q_entry.x;
                    y_next = q_entry.y;
                    z_next = q_entry.z;
                    case (q_entry.op)
                        vfcm_pkg::OP_WRITE: begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = vfcm_pkg::cell_addr(q_entry.x, q_entry.y, q_entry.z);
                            ram_wr_data = q_entry.value;
                        end
                        vfcm_pkg::OP_READ: begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = vfcm_pkg::cell_addr(q_entry.x, q_entry.y, q_entry.z);
                            oob_next    = 1'b0;
                            state_next  = vfcm_pkg::ST_READ_OUT;
                        end
                        vfcm_pkg::OP_READ_OOB: begin
                            oob_next   = 1'b1;
                            state_next = vfcm_pkg::ST_READ_OUT;
                        end
                        vfcm_pkg::OP_MESH: begin
                            pos_x_next      = {base_x_reg[vfcm_pkg::BASE_W-1], base_x_reg} +
                                              VERT_W'(q_entry.x);
                            pos_y_next      = {base_y_reg[vfcm_pkg::BASE_W-1], base_y_reg} +
                                              VERT_W'(q_entry.y);
                            pos_z_next      = {base_z_reg[vfcm_pkg::BASE_W-1], base_z_reg} +
                                              VERT_W'(q_entry.z);
                            probe_cnt_next  = '0;
                            empty_mask_next = '0;
                            center_nz_next  = 1'b0;
                            state_next      = vfcm_pkg::ST_PROBE;
                        end
                        default: ;
                    endcase
                end
            end

            // single read result
            vfcm_pkg::ST_READ_OUT: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_is_vertex_next  = 1'b0;
                    out_read_value_next = oob_reg ? '1 : ram_rd_data;
                    out_vert_x_next     = '0;
                    out_vert_y_next     = '0;
                    out_vert_z_next     = '0;
                    out_norm_next       = '0;
                    out_last_next       = 1'b1;
                    state_next          = vfcm_pkg::ST_IDLE;
                end
            end

            // read the cell, then its six neighbors, one per cycle
            vfcm_pkg::ST_PROBE: begin
                if (probe_cnt_reg <= vfcm_pkg::PROBE_W'(vfcm_pkg::NUM_FACES)) begin
                    ram_rd_en = 1'b1;
                    if (probe_cnt_reg != '0) begin
                        ram_rd_addr = vfcm_pkg::cell_addr(nbr_x, nbr_y, nbr_z);
                    end
                end
                if (probe_cnt_reg == vfcm_pkg::PROBE_W'(1)) begin
                    center_nz_next = (ram_rd_data != '0);
                end else if (probe_cnt_reg >= vfcm_pkg::PROBE_W'(2)) begin
                    empty_mask_next[vfcm_pkg::FACE_W'(probe_cnt_reg - vfcm_pkg::PROBE_W'(2))] =
                        (ram_rd_data == '0);
                end
                if (probe_cnt_reg == vfcm_pkg::PROBE_W'(vfcm_pkg::NUM_FACES + 1)) begin
                    if (center_nz_reg && (empty_mask_next != '0)) begin
                        face_next  = vfcm_pkg::first_face(empty_mask_next);
                        vert_next  = '0;
                        state_next = vfcm_pkg::ST_EMIT;
                    end else begin
                        state_next = vfcm_pkg::ST_IDLE;
                    end
                end else begin
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end

            // one vertex per cycle over the open faces, while the output register is free
            vfcm_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_is_vertex_next  = 1'b1;
                    out_read_value_next = '0;
                    out_vert_x_next     = pos_x_reg + VERT_W'(corner[0]);
                    out_vert_y_next     = pos_y_reg + VERT_W'(corner[1]);
                    out_vert_z_next     = pos_z_reg + VERT_W'(corner[2]);
                    out_norm_next       = vfcm_pkg::face_normal(face_reg);
                    out_last_next       = (vert_reg == 3'(vfcm_pkg::VERTS_PER_FACE - 1)) &&
                                          !more_faces;
                    if (vert_reg == 3'(vfcm_pkg::VERTS_PER_FACE - 1)) begin
                        vert_next = '0;
                        if (more_faces) begin
                            face_next = vfcm_pkg::first_face(higher_mask);
                        end else begin
                            state_next = vfcm_pkg::ST_IDLE;
                        end
                    end else begin
                        vert_next = vert_reg + 1'b1;
                    end
                end
            end

            default: begin
                state_next = vfcm_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vfcm_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            base_x_reg  <= '0;
            base_y_reg  <= '0;
            base_z_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            base_x_reg  <= base_x_next;
            base_y_reg  <= base_y_next;
            base_z_reg  <= base_z_next;
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        z_reg          <= z_next;
        oob_reg        <= oob_next;
        pos_x_reg      <= pos_x_next;
        pos_y_reg      <= pos_y_next;
        pos_z_reg      <= pos_z_next;
        probe_cnt_reg  <= probe_cnt_next;
        center_nz_reg  <= center_nz_next;
        empty_mask_reg <= empty_mask_next;
        face_reg       <= face_next;
        vert_reg       <= vert_next;
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_is_vertex_reg  <= out_is_vertex_next;
            out_read_value_reg <= out_read_value_next;
            out_vert_x_reg     <= out_vert_x_next;
            out_vert_y_reg     <= out_vert_y_next;
            out_vert_z_reg     <= out_vert_z_next;
            out_norm_reg       <= out_norm_next;
            out_last_reg       <= out_last_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_is_vertex_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = vfcm_pkg::M_TDATA_W'({out_norm_reg.z, out_norm_reg.y, out_norm_reg.x,
                                                 out_vert_z_reg, out_vert_y_reg, out_vert_x_reg,
                                                 out_read_value_reg});

    `VFCM_ASSERT_SAME(a_no_pop_in_clear, aclk, aresetn, state_reg == vfcm_pkg::ST_CLEAR, !q_pop, "command taken during the clearing pass")
    `VFCM_ASSERT_SAME(a_emit_open_face, aclk, aresetn, state_reg == vfcm_pkg::ST_EMIT, center_nz_reg && empty_mask_reg[face_reg], "vertex emitted for a closed face or empty cell")
    `VFCM_ASSERT_NEXT(a_last_ends_mesh, aclk, aresetn, (state_reg == vfcm_pkg::ST_EMIT) && out_load && out_last_next, (state_reg == vfcm_pkg::ST_IDLE) && m_axis_tlast, "mesh did not end after its last vertex")

endmodule

// File: src/voxel_face_culling_mesher_unit.sv
// top level of the voxel face-culling mesher
//
// Input stream s_axis carries one command per item: tuser is the function
// (write, read, mesh one cell), tdata the cell coordinates and the voxel value.
// Output stream m_axis carries read data (tuser 0) or mesh vertices (tuser 1);
// tlast marks the final result of each command. The cfg port writes the
// section origin registers base_x, base_y, base_z; it never stalls. The user
// must write it only while no command is in flight; the block does not enforce it.
// The back end writes a cell as it takes the write from the queue. A read
// goes through the registered memory read port, then the output register.
// A mesh request leaves the queue, then the cell and its six neighbors are
// read from the single-read voxel memory, and then its vertices, up to 36,
// go to the output register in turn while it is free. Commands that
// produce nothing (out-of-range writes, border cells, the unused function)
// are dropped in the front end and never reach the back end.
// After reset the voxel memory is cleared one cell per cycle,
// with s_axis_tready low. A two-entry command queue parts front and back; when
// the receiver stalls, the output register holds, the back end waits and the
// queue fills before s_axis_tready drops.
module voxel_face_culling_mesher_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cell_x[6:0], cell_y[13:7], cell_z[20:14], voxel_value[28:21], zero pad
    input  logic [vfcm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [vfcm_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_value[7:0], vert_x[32:8], vert_y[57:33], vert_z[82:58],
    // norm_x[84:83], norm_y[86:85], norm_z[88:87], zero pad
    output logic [vfcm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // is_vertex[0]
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vfcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vfcm_pkg::BASE_W-1:0]       cfg_data
);

    logic           q_valid;
    vfcm_pkg::cmd_t q_entry;
    logic           q_pop;
    logic           clear_busy;

    vfcm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .clear_busy    (clear_busy),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop)
    );

    vfcm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .clear_busy    (clear_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: test/voxel_face_culling_mesher_unit_tb.sv
// testbench of the voxel face-culling mesher: grid access, face culling, origin extremes, backpressure, random sweeps
module voxel_face_culling_mesher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID          = vfcm_pkg::SECTION_SIZE;
    localparam int SWEEP_ITEMS   = 45;
    localparam int SWEEP_PHASES  = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 12000;
    localparam int IDLE_PERCENT  = 35;

    // codes the package leaves unnamed
    localparam logic [vfcm_pkg::FUNC_W-1:0]      FUNC_UNUSED = 2'd3;
    localparam logic [vfcm_pkg::CFG_INDEX_W-1:0] REG_UNUSED  = 2'd3;

    localparam logic [vfcm_pkg::BASE_W-1:0] BASE_MAX = 24'h7FFFFF;
    localparam logic [vfcm_pkg::BASE_W-1:0] BASE_MIN = 24'h800000;

    // cell indexes at and beyond the grid edge
    localparam logic [vfcm_pkg::CELL_W-1:0] CELL_TOP = vfcm_pkg::CELL_W'(GRID - 1);
    localparam logic [vfcm_pkg::CELL_W-1:0] CELL_OUT = vfcm_pkg::CELL_W'(GRID);
    localparam logic [vfcm_pkg::CELL_W-1:0] CELL_FAR = 7'd127;

    // one output item split into its fields
    typedef struct packed {
        logic                         is_vertex;
        logic [vfcm_pkg::VOXEL_W-1:0] read_value;
        logic [vfcm_pkg::VERT_W-1:0]  vx;
        logic [vfcm_pkg::VERT_W-1:0]  vy;
        logic [vfcm_pkg::VERT_W-1:0]  vz;
        logic [vfcm_pkg::NORM_W-1:0]  nx;
        logic [vfcm_pkg::NORM_W-1:0]  ny;
        logic [vfcm_pkg::NORM_W-1:0]  nz;
        logic                         last;
    } mesh_out_t;

    logic                              aclk          = 1'b0;
    logic                              aresetn       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [vfcm_pkg::S_TDATA_W-1:0]    s_axis_tdata  = '0;
    logic [vfcm_pkg::FUNC_W-1:0]       s_axis_tuser  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [vfcm_pkg::M_TDATA_W-1:0]    m_axis_tdata;
    logic                              m_axis_tuser;
    logic                              m_axis_tlast;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    logic [vfcm_pkg::CFG_INDEX_W-1:0]  cfg_index     = '0;
    logic [vfcm_pkg::BASE_W-1:0]       cfg_data      = '0;

    // predictor state: voxel grid and section origin
    logic [vfcm_pkg::VOXEL_W-1:0]       voxel_grid [GRID][GRID][GRID];
    logic signed [vfcm_pkg::BASE_W-1:0] origin_x = '0;
    logic signed [vfcm_pkg::BASE_W-1:0] origin_y = '0;
    logic signed [vfcm_pkg::BASE_W-1:0] origin_z = '0;

    mesh_out_t due_outputs[$];
    int        mismatch_count = 0;
    int        items_counted  = 0;
    int        hold_requests  = 0;
    bit        idle_on        = 1'b1;

    voxel_face_culling_mesher_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // direction to the neighbor of a face, also its normal: {x, y, z}
    function automatic logic [3*vfcm_pkg::NORM_W-1:0] face_dir(input int f);
        case (f)
            vfcm_pkg::FACE_NEG_X: return {2'b11, 2'b00, 2'b00};
            vfcm_pkg::FACE_POS_X: return {2'b01, 2'b00, 2'b00};
            vfcm_pkg::FACE_NEG_Z: return {2'b00, 2'b00, 2'b11};
            vfcm_pkg::FACE_POS_Z: return {2'b00, 2'b00, 2'b01};
            vfcm_pkg::FACE_NEG_Y: return {2'b00, 2'b11, 2'b00};
            default:              return {2'b00, 2'b01, 2'b00};
        endcase
    endfunction

    // six corners of a face as {x, y, z} bits, first corner in the top bits
    function automatic logic [17:0] face_corners(input int f);
        case (f)
            vfcm_pkg::FACE_NEG_X: return {3'b000, 3'b001, 3'b011, 3'b000, 3'b011, 3'b010};
            vfcm_pkg::FACE_POS_X: return {3'b101, 3'b100, 3'b110, 3'b101, 3'b110, 3'b111};
            vfcm_pkg::FACE_NEG_Z: return {3'b100, 3'b000, 3'b010, 3'b100, 3'b010, 3'b110};
            vfcm_pkg::FACE_POS_Z: return {3'b001, 3'b101, 3'b111, 3'b001, 3'b111, 3'b011};
            vfcm_pkg::FACE_NEG_Y: return {3'b000, 3'b100, 3'b101, 3'b000, 3'b101, 3'b001};
            default:              return {3'b011, 3'b111, 3'b110, 3'b011, 3'b110, 3'b010};
        endcase
    endfunction

    // update the grid and queue the outputs one accepted command causes
    task automatic apply_command(input logic [vfcm_pkg::FUNC_W-1:0] fn,
                                 input logic [vfcm_pkg::CELL_W-1:0] cx,
                                 input logic [vfcm_pkg::CELL_W-1:0] cy,
                                 input logic [vfcm_pkg::CELL_W-1:0] cz,
                                 input logic [vfcm_pkg::VOXEL_W-1:0] val);
        mesh_out_t                      r;
        logic                           in_grid;
        logic                           interior;
        logic [vfcm_pkg::NUM_FACES-1:0] open_faces;
        logic [5:0]                     dir;
        logic [17:0]                    corners;
        logic [2:0]                     c;
        int                             px, py, pz, nx, ny, nz, f, v, left;
        in_grid  = cx < GRID && cy < GRID && cz < GRID;
        interior = cx >= 1 && cy >= 1 && cz >= 1
                   && cx <= GRID - 2 && cy <= GRID - 2 && cz <= GRID - 2;
        case (fn)
            vfcm_pkg::FUNC_WRITE: begin
                if (in_grid) begin
                    voxel_grid[cx][cy][cz] = val;
                    items_counted++;
                end
            end
            vfcm_pkg::FUNC_READ: begin
                r = '0;
                r.read_value = in_grid ? voxel_grid[cx][cy][cz] : 8'hFF;
                r.last = 1'b1;
                due_outputs.push_back(r);
                items_counted++;
            end
            vfcm_pkg::FUNC_MESH: begin
                items_counted++;
                if (interior && voxel_grid[cx][cy][cz] != '0) begin
                    // faces whose neighbor is empty
                    open_faces = '0;
                    left = 0;
                    for (f = 0; f < vfcm_pkg::NUM_FACES; f++) begin
                        dir = face_dir(f);
                        nx = int'(cx) + int'($signed(dir[5:4]));
                        ny = int'(cy) + int'($signed(dir[3:2]));
                        nz = int'(cz) + int'($signed(dir[1:0]));
                        if (voxel_grid[nx][ny][nz] == '0) begin
                            open_faces[f] = 1'b1;
                            left += vfcm_pkg::VERTS_PER_FACE;
                        end
                    end
                    px = int'(origin_x) + int'(cx);
                    py = int'(origin_y) + int'(cy);
                    pz = int'(origin_z) + int'(cz);
                    for (f = 0; f < vfcm_pkg::NUM_FACES; f++) begin
                        if (open_faces[f]) begin
                            dir     = face_dir(f);
                            corners = face_corners(f);
                            for (v = 0; v < vfcm_pkg::VERTS_PER_FACE; v++) begin
                                c = corners[(5 - v) * 3 +: 3];
                                r = '0;
                                r.is_vertex = 1'b1;
                                r.vx = vfcm_pkg::VERT_W'(px + int'(c[2]));
                                r.vy = vfcm_pkg::VERT_W'(py + int'(c[1]));
                                r.vz = vfcm_pkg::VERT_W'(pz + int'(c[0]));
                                r.nx = dir[5:4];
                                r.ny = dir[3:2];
                                r.nz = dir[1:0];
                                left--;
                                r.last = (left == 0);
                                due_outputs.push_back(r);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // compare one output item with the oldest expectation
    task automatic match_output();
        mesh_out_t got, want;
        got.is_vertex  = m_axis_tuser;
        got.read_value = m_axis_tdata[7:0];
        got.vx         = m_axis_tdata[32:8];
        got.vy         = m_axis_tdata[57:33];
        got.vz         = m_axis_tdata[82:58];
        got.nx         = m_axis_tdata[84:83];
        got.ny         = m_axis_tdata[86:85];
        got.nz         = m_axis_tdata[88:87];
        got.last       = m_axis_tlast;
        if (due_outputs.size() == 0) begin
            report_mismatch("output item with nothing expected");
        end else begin
            want = due_outputs.pop_front();
            check_field("is_vertex", 32'(got.is_vertex), 32'(want.is_vertex));
            check_field("read_value", 32'(got.read_value), 32'(want.read_value));
            check_field("vert_x", 32'(got.vx), 32'(want.vx));
            check_field("vert_y", 32'(got.vy), 32'(want.vy));
            check_field("vert_z", 32'(got.vz), 32'(want.vz));
            check_field("norm_x", 32'(got.nx), 32'(want.nx));
            check_field("norm_y", 32'(got.ny), 32'(want.ny));
            check_field("norm_z", 32'(got.nz), 32'(want.nz));
            check_field("last", 32'(got.last), 32'(want.last));
        end
    endtask

    // output side: check accepted items, random stalls, long hold on request
    initial begin : output_sink
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                match_output();
            end
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // watchdog on cycles with no accepted item anywhere
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("voxel_face_culling_mesher_unit test failed");
        $finish;
    end

    // offer one command, with a random gap before it
    task automatic send_cmd(input logic [vfcm_pkg::FUNC_W-1:0] fn,
                            input logic [vfcm_pkg::CELL_W-1:0] cx,
                            input logic [vfcm_pkg::CELL_W-1:0] cy,
                            input logic [vfcm_pkg::CELL_W-1:0] cz,
                            input logic [vfcm_pkg::VOXEL_W-1:0] val);
        if (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < IDLE_PERCENT);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {3'b000, val, cz, cy, cx};
        do @(posedge aclk); while (!s_axis_tready);
        apply_command(fn, cx, cy, cz, val);
    endtask

    task automatic write_reg(input logic [vfcm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [vfcm_pkg::BASE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            vfcm_pkg::REG_BASE_X: origin_x = data;
            vfcm_pkg::REG_BASE_Y: origin_y = data;
            vfcm_pkg::REG_BASE_Z: origin_z = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering, let every expected item arrive, then let the back end settle
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_origin(input logic [vfcm_pkg::BASE_W-1:0] bx,
                              input logic [vfcm_pkg::BASE_W-1:0] by,
                              input logic [vfcm_pkg::BASE_W-1:0] bz);
        wait_until_idle();
        write_reg(vfcm_pkg::REG_BASE_X, bx);
        write_reg(vfcm_pkg::REG_BASE_Y, by);
        write_reg(vfcm_pkg::REG_BASE_Z, bz);
    endtask

    // reads and writes at the grid corners, out of range, and the unused function
    task automatic test_grid_access();
        send_cmd(vfcm_pkg::FUNC_READ, 0, 0, 0, 8'h00);
        send_cmd(vfcm_pkg::FUNC_READ, CELL_TOP, CELL_TOP, CELL_TOP, 8'h00);
        send_cmd(vfcm_pkg::FUNC_WRITE, 0, 0, 0, 8'h80);
        send_cmd(vfcm_pkg::FUNC_WRITE, CELL_TOP, CELL_TOP, CELL_TOP, 8'h7F);
        send_cmd(vfcm_pkg::FUNC_WRITE, CELL_OUT, 3, 3, 8'h55);
        send_cmd(vfcm_pkg::FUNC_WRITE, 3, CELL_FAR, 3, 8'h2A);
        send_cmd(vfcm_pkg::FUNC_READ, 0, 0, 0, 8'h00);
        send_cmd(vfcm_pkg::FUNC_READ, CELL_TOP, CELL_TOP, CELL_TOP, 8'h00);
        send_cmd(vfcm_pkg::FUNC_READ, CELL_OUT, 3, 3, 8'h00);
        send_cmd(vfcm_pkg::FUNC_READ, 3, CELL_FAR, 3, 8'h00);
        send_cmd(vfcm_pkg::FUNC_READ, 3, 3, CELL_OUT, 8'h00);
        send_cmd(FUNC_UNUSED, CELL_FAR, CELL_FAR, CELL_FAR, 8'hFF);
        send_cmd(vfcm_pkg::FUNC_READ, 3, 3, 3, 8'h00);
    endtask

    // lone cell, border cells, empty cell, one covered face
    task automatic test_face_culling();
        send_cmd(vfcm_pkg::FUNC_WRITE, 5, 5, 5, 8'h01);
        send_cmd(vfcm_pkg::FUNC_MESH, 5, 5, 5, 8'h00);
        send_cmd(vfcm_pkg::FUNC_WRITE, 0, 5, 5, 8'h03);
        send_cmd(vfcm_pkg::FUNC_MESH, 0, 5, 5, 8'h00);
        send_cmd(vfcm_pkg::FUNC_MESH, CELL_TOP, CELL_TOP, CELL_TOP, 8'h00);
        send_cmd(vfcm_pkg::FUNC_MESH, 7, 7, 7, 8'h00);
        send_cmd(vfcm_pkg::FUNC_WRITE, 6, 5, 5, 8'hFF);
        send_cmd(vfcm_pkg::FUNC_MESH, 5, 5, 5, 8'h00);
    endtask

    // origin at the limits of its range, and the unused register index
    task automatic test_origin_extremes();
        set_origin(BASE_MAX, BASE_MIN, BASE_MAX);
        write_reg(REG_UNUSED, vfcm_pkg::BASE_W'($urandom_range(0, 24'hFFFFFF)));
        send_cmd(vfcm_pkg::FUNC_MESH, 5, 5, 5, 8'h00);
        set_origin(BASE_MIN, BASE_MAX, BASE_MIN);
        send_cmd(vfcm_pkg::FUNC_MESH, 5, 5, 5, 8'h00);
    endtask

    // receiver holds off while full-face meshes keep coming
    task automatic test_backpressure();
        int i;
        for (i = 2; i <= GRID - 4; i += 2) begin
            send_cmd(vfcm_pkg::FUNC_WRITE, vfcm_pkg::CELL_W'(i), 10, 10,
                     vfcm_pkg::VOXEL_W'($urandom_range(1, 255)));
        end
        hold_requests <= hold_requests + 1;
        for (i = 2; i <= GRID - 4; i += 2) begin
            send_cmd(vfcm_pkg::FUNC_MESH, vfcm_pkg::CELL_W'(i), 10, 10, 8'h00);
            send_cmd(vfcm_pkg::FUNC_MESH, vfcm_pkg::CELL_W'(i), 10, 10, 8'h00);
        end
    endtask

    // fill a small box at random density, then mesh it in sweep order and send up to two random reads
    task automatic run_sweep_block();
        int ox, oy, oz, sx, sy, sz, x, y, z, density, n;
        sx = $urandom_range(1, 3);
        sy = $urandom_range(1, 3);
        sz = $urandom_range(1, 3);
        ox = $urandom_range(0, GRID - sx);
        oy = $urandom_range(0, GRID - sy);
        oz = $urandom_range(0, GRID - sz);
        density = $urandom_range(30, 100);
        for (x = ox; x < ox + sx; x++) begin
            for (y = oy; y < oy + sy; y++) begin
                for (z = oz; z < oz + sz; z++) begin
                    send_cmd(vfcm_pkg::FUNC_WRITE, vfcm_pkg::CELL_W'(x), vfcm_pkg::CELL_W'(y),
                             vfcm_pkg::CELL_W'(z),
                             vfcm_pkg::VOXEL_W'(($urandom_range(0, 99) < density) ?
                                                $urandom_range(1, 255) : 0));
                end
            end
        end
        for (x = ox; x < ox + sx; x++) begin
            for (y = oy; y < oy + sy; y++) begin
                for (z = oz; z < oz + sz; z++) begin
                    send_cmd(vfcm_pkg::FUNC_MESH, vfcm_pkg::CELL_W'(x), vfcm_pkg::CELL_W'(y),
                             vfcm_pkg::CELL_W'(z), vfcm_pkg::VOXEL_W'($urandom_range(0, 255)));
                end
            end
        end
        n = $urandom_range(0, 2);
        repeat (n) begin
            send_cmd(vfcm_pkg::FUNC_READ, vfcm_pkg::CELL_W'($urandom_range(0, GRID - 1)),
                     vfcm_pkg::CELL_W'($urandom_range(0, GRID - 1)),
                     vfcm_pkg::CELL_W'($urandom_range(0, GRID - 1)),
                     vfcm_pkg::VOXEL_W'($urandom_range(0, 255)));
        end
    endtask

    // random phases, each under its own origin; one phase without idling
    task automatic test_random_sweeps();
        int phase, goal;
        for (phase = 0; phase < SWEEP_PHASES; phase++) begin
            case (phase)
                0:       set_origin(BASE_MAX, BASE_MAX, BASE_MAX);
                1:       set_origin(BASE_MIN, BASE_MIN, BASE_MIN);
                3:       set_origin('0, '0, '0);
                default: set_origin(vfcm_pkg::BASE_W'($urandom_range(0, 24'hFFFFFF)),
                                    vfcm_pkg::BASE_W'($urandom_range(0, 24'hFFFFFF)),
                                    vfcm_pkg::BASE_W'($urandom_range(0, 24'hFFFFFF)));
            endcase
            idle_on = (phase != 3);
            goal = items_counted + SWEEP_ITEMS;
            while (items_counted < goal) begin
                if ($urandom_range(0, 99) < 80) begin
                    run_sweep_block();
                end else begin
                    send_cmd(vfcm_pkg::FUNC_W'($urandom_range(0, 3)),
                             vfcm_pkg::CELL_W'($urandom_range(0, 127)),
                             vfcm_pkg::CELL_W'($urandom_range(0, 127)),
                             vfcm_pkg::CELL_W'($urandom_range(0, 127)),
                             vfcm_pkg::VOXEL_W'($urandom_range(0, 255)));
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // sequence of tests
    initial begin
        for (int x = 0; x < GRID; x++) begin
            for (int y = 0; y < GRID; y++) begin
                for (int z = 0; z < GRID; z++) begin
                    voxel_grid[x][y][z] = '0;
                end
            end
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_origin('0, 24'h000123, 24'hFFFF00);
        test_grid_access();
        test_face_culling();
        test_origin_extremes();
        test_backpressure();
        test_random_sweeps();
        wait_until_idle();
        if (due_outputs.size() != 0) begin
            report_mismatch($sformatf("%0d expected items never arrived", due_outputs.size()));
        end
        if (mismatch_count == 0) begin
            $display("voxel_face_culling_mesher_unit test passed");
        end else begin
            $display("voxel_face_culling_mesher_unit test failed");
        end
        $finish;
    end

endmodule
